### rtl/core/byte_ring_buffer_unit_defines.svh
// Assertion helpers used by byte_ring_buffer_unit.
`ifndef BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// Checked on every rising edge of clk while rst is low.
`define BRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define BRB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/brb_pkg.sv
package brb_pkg;

  localparam int CNT_W = 11;
  localparam int DEPTH_DEFAULT = 1024;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_DISCARD = 2'd2;
  localparam logic [1:0] CMD_COMMIT  = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       write_data;
    logic [CNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             error;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] read_span;
    logic [CNT_W-1:0] write_span;
  } out_item_t;

endpackage

### rtl/core/brb_ram.sv
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/byte_ring_buffer_unit.sv
// Circular byte FIFO over a DEPTH x 8 single-port-write, registered-read store.
// Each accepted item is one command (write byte, read byte, discard N, commit N)
// and yields exactly one result with read data, error, fill count and the
// contiguous readable and writable spans. Items are accepted back to back, one
// per cycle, as long as the output is not stalled and no clearing pass runs.
// An accepted item waits in a pending stage, reading its byte from the store's
// registered read port, then moves into the output register as its result.
// After reset the store is zeroed by a clearing pass over every address during
// which in_stall is high. Writing the capacity register empties the FIFO
// (indices and fill count go to zero) but keeps the store contents; a capacity
// of 0 acts as 1 and one above DEPTH acts as DEPTH. Write it only while idle.
`include "byte_ring_buffer_unit_defines.svh"

module byte_ring_buffer_unit #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [brb_pkg::CNT_W-1:0]   cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  brb_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output brb_pkg::out_item_t          out_data
);

  localparam int CNT_W = brb_pkg::CNT_W;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int AW = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(DEPTH - 1);

  function automatic logic [AW-1:0] clamp_cap(input logic [CNT_W-1:0] v);
    logic [AW-1:0] x;
    x = AW'(v);
    if (x == '0) begin
      x = AW'(1);
    end else if (x > AW'(DEPTH)) begin
      x = AW'(DEPTH);
    end
    return x;
  endfunction

  // idx < cap and n <= cap, so one conditional subtract wraps it
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [AW-1:0] n,
                                            input logic [AW-1:0] cap);
    logic [AW-1:0] s;
    s = idx + n;
    if (s >= cap) begin
      s = s - cap;
    end
    return s;
  endfunction

  logic [AW-1:0]    cap_use;
  logic [IDX_W-1:0] ri;
  logic [IDX_W-1:0] wi;
  logic [CNT_W-1:0] held;

  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  logic             pend_valid;
  logic             pend_err;
  logic             pend_rd;
  logic             pend_move;

  logic             in_fire;
  logic             in_err;
  logic             in_rd_ok;
  logic             in_wr_ok;
  logic [AW-1:0]    ri_next;
  logic [AW-1:0]    wi_next;
  logic [AW-1:0]    held_next;

  logic [AW-1:0]    ri_x;
  logic [AW-1:0]    wi_x;
  logic [AW-1:0]    held_x;
  logic [AW-1:0]    amt_x;
  logic [AW-1:0]    free_x;
  logic [AW-1:0]    rtail;
  logic [AW-1:0]    wtail;
  logic [AW-1:0]    rspan;
  logic [AW-1:0]    wspan;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  assign pend_move = pend_valid && (!out_valid || !out_stall);
  assign in_stall  = clearing || (pend_valid && !pend_move);
  assign in_fire   = in_valid && !in_stall;

  assign ri_x   = AW'(ri);
  assign wi_x   = AW'(wi);
  assign held_x = AW'(held);
  assign amt_x  = AW'(in_data.amount);
  assign free_x = cap_use - held_x;

  always_comb begin
    in_err    = 1'b0;
    in_rd_ok  = 1'b0;
    in_wr_ok  = 1'b0;
    ri_next   = ri_x;
    wi_next   = wi_x;
    held_next = held_x;
    case (in_data.cmd)
      brb_pkg::CMD_WRITE: begin
        in_err = (free_x == '0);
        if (!in_err) begin
          in_wr_ok  = 1'b1;
          wi_next   = advance(wi_x, AW'(1), cap_use);
          held_next = held_x + AW'(1);
        end
      end
      brb_pkg::CMD_READ: begin
        in_err = (held_x == '0);
        if (!in_err) begin
          in_rd_ok  = 1'b1;
          ri_next   = advance(ri_x, AW'(1), cap_use);
          held_next = held_x - AW'(1);
        end
      end
      brb_pkg::CMD_DISCARD: begin
        in_err = (amt_x > held_x);
        if (!in_err) begin
          ri_next   = advance(ri_x, amt_x, cap_use);
          held_next = held_x - amt_x;
        end
      end
      default: begin
        in_err = (amt_x > free_x);
        if (!in_err) begin
          wi_next   = advance(wi_x, amt_x, cap_use);
          held_next = held_x + amt_x;
        end
      end
    endcase
  end

  // store writes: clearing pass first, then accepted write commands
  assign ram_we    = clearing || (in_fire && in_wr_ok);
  assign ram_waddr = clearing ? clr_addr : wi;
  assign ram_wdata = clearing ? 8'd0 : in_data.write_data;

  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ri),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_use <= clamp_cap(brb_pkg::CAP_RESET);
      ri      <= '0;
      wi      <= '0;
      held    <= '0;
    end else if (cfg_write_en) begin
      cap_use <= clamp_cap(cfg_write_data);
      ri      <= '0;
      wi      <= '0;
      held    <= '0;
    end else if (in_fire) begin
      ri   <= ri_next[IDX_W-1:0];
      wi   <= wi_next[IDX_W-1:0];
      held <= held_next[CNT_W-1:0];
    end
  end

  // While pend_valid, the index and count registers hold exactly the state
  // left by the pending item, so the spans are formed from them here.
  assign rtail = cap_use - ri_x;
  assign wtail = cap_use - wi_x;
  assign rspan = (held_x < rtail) ? held_x : rtail;
  assign wspan = (free_x < wtail) ? free_x : wtail;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_err <= in_err;
      pend_rd  <= in_rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data.read_data  <= pend_rd ? ram_rdata : 8'd0;
      out_data.error      <= pend_err;
      out_data.fill_count <= held;
      out_data.read_span  <= rspan[CNT_W-1:0];
      out_data.write_span <= wspan[CNT_W-1:0];
    end
  end

  `BRB_ASSERT(a_held_within_cap, AW'(held) <= cap_use, "fill count exceeds capacity in use")
  `BRB_ASSERT(a_idx_within_cap, (ri_x < cap_use) && (wi_x < cap_use), "index beyond capacity")
  `BRB_ASSERT(a_err_keeps_state, in_fire && in_err && !cfg_write_en |=> held == $past(held) && ri == $past(ri) && wi == $past(wi), "rejected command changed state")
  `BRB_ASSERT(a_clear_full_sweep, $fell(clearing) |-> $past(clr_addr) == CLR_LAST, "clearing pass ended early")
  `BRB_ASSERT_ALWAYS(a_no_accept_in_reset, rst |=> !out_valid && !pend_valid, "result pending after reset")

endmodule
